[src/ihds_pkg.sv]
// ----------------------------------------------------------------------------
// ihds_pkg
// Shared types, byte codes and small lookup functions for the image header
// dimension sniffer.
// ----------------------------------------------------------------------------
package ihds_pkg;

  // Default width of the saturating byte position counter
  localparam int unsigned POSITION_BITS_DEF = 32;

  // Format codes, as reported on the result port
  typedef enum logic [1:0] {
    FMT_NONE = 2'd0,
    FMT_PNG  = 2'd1,
    FMT_BMP  = 2'd2,
    FMT_JPEG = 2'd3
  } fmt_t;

  // Decision state of the current file
  typedef enum logic [2:0] {
    DEC_OPEN  = 3'b001,
    DEC_FOUND = 3'b010,
    DEC_NONE  = 3'b100
  } dec_t;

  // JPEG marker walk phases
  typedef enum logic [5:0] {
    PH_SEEK  = 6'b000001,
    PH_MARK  = 6'b000010,
    PH_LENHI = 6'b000100,
    PH_LENLO = 6'b001000,
    PH_SKIP  = 6'b010000,
    PH_SOF   = 6'b100000
  } phase_t;

  // Leading bytes
  localparam logic [7:0] LEAD_PNG  = 8'h89;
  localparam logic [7:0] LEAD_BMP  = 8'h42;
  localparam logic [7:0] BMP_SECOND = 8'h4D;

  // JPEG marker bytes
  localparam logic [7:0] MRK_PREFIX = 8'hFF;
  localparam logic [7:0] MRK_SOI    = 8'hD8;
  localparam logic [7:0] MRK_EOI    = 8'hD9;
  localparam logic [7:0] MRK_SOS    = 8'hDA;
  localparam logic [7:0] MRK_TEM    = 8'h01;
  localparam logic [7:0] MRK_RST0   = 8'hD0;
  localparam logic [7:0] MRK_RST7   = 8'hD7;
  localparam logic [7:0] MRK_DHT    = 8'hC4;
  localparam logic [7:0] MRK_JPG    = 8'hC8;
  localparam logic [7:0] MRK_DAC    = 8'hCC;
  localparam logic [7:0] MRK_SOF_LO = 8'hC0;
  localparam logic [7:0] MRK_SOF_HI = 8'hCF;

  // Counter values inside an SOF segment (counter starts at 4 on precision)
  localparam logic [15:0] SOF_START  = 16'd4;
  localparam logic [15:0] SOF_HGT_HI = 16'd5;
  localparam logic [15:0] SOF_HGT_LO = 16'd6;
  localparam logic [15:0] SOF_WID_HI = 16'd7;
  localparam logic [15:0] SOF_WID_LO = 16'd8;
  localparam logic [15:0] SOF_COMP   = 16'd9;

  // Default channel count
  localparam logic [7:0] CHAN_DEF = 8'd3;

  // Events from the JPEG walker to the capture logic
  typedef struct packed {
    logic dec_none;
    logic dec_found;
    logic hgt_hi;
    logic hgt_lo;
    logic wid_hi;
    logic wid_lo;
  } jpeg_evt_t;

  // PNG signature byte at position idx
  function automatic logic [7:0] png_magic(input logic [2:0] idx);
    logic [7:0] val;
    unique case (idx)
      3'd0:    val = 8'h89;
      3'd1:    val = 8'h50;
      3'd2:    val = 8'h4E;
      3'd3:    val = 8'h47;
      3'd4:    val = 8'h0D;
      3'd5:    val = 8'h0A;
      3'd6:    val = 8'h1A;
      default: val = 8'h0A;
    endcase
    return val;
  endfunction

  // IHDR chunk tag byte at position idx
  function automatic logic [7:0] png_ihdr(input logic [1:0] idx);
    logic [7:0] val;
    unique case (idx)
      2'd0:    val = 8'h49;
      2'd1:    val = 8'h48;
      2'd2:    val = 8'h44;
      default: val = 8'h52;
    endcase
    return val;
  endfunction

  // Start-of-frame markers carry dimensions; DHT, JPG and DAC share the range
  function automatic logic is_sof(input logic [7:0] m);
    return (m >= MRK_SOF_LO) && (m <= MRK_SOF_HI) &&
           (m != MRK_DHT) && (m != MRK_JPG) && (m != MRK_DAC);
  endfunction

  // Magnitude of a signed 32-bit value; the most negative value maps to itself
  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (32'd0 - v) : v;
  endfunction

endpackage

[src/ihds_jpeg.sv]
// ----------------------------------------------------------------------------
// ihds_jpeg
// JPEG marker segment walker: passes standalone markers, skips segment
// bodies and flags the SOF bytes that carry height, width and components.
// ----------------------------------------------------------------------------
module ihds_jpeg (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  clr,
  input  logic [7:0]            byte_value,
  output ihds_pkg::jpeg_evt_t   evt
);

  ihds_pkg::phase_t phase, phase_next;
  logic [7:0]       marker, marker_next;
  logic [7:0]       len_hi, len_hi_next;
  logic [15:0]      count, count_next;
  logic [15:0]      seg_len;
  logic [15:0]      count_dec;

  assign seg_len   = {len_hi, byte_value};
  assign count_dec = count - 16'd1;

  // Walk one byte
  always_comb begin
    phase_next  = phase;
    marker_next = marker;
    len_hi_next = len_hi;
    count_next  = count;
    evt         = '0;
    unique case (phase)
      ihds_pkg::PH_SEEK: begin
        if (byte_value == ihds_pkg::MRK_PREFIX) begin
          phase_next = ihds_pkg::PH_MARK;
        end
      end
      ihds_pkg::PH_MARK: begin
        priority if (byte_value == ihds_pkg::MRK_EOI ||
                     byte_value == ihds_pkg::MRK_SOS) begin
          evt.dec_none = 1'b1;
        end else if (byte_value == ihds_pkg::MRK_SOI ||
                     byte_value == ihds_pkg::MRK_TEM ||
                     (byte_value >= ihds_pkg::MRK_RST0 &&
                      byte_value <= ihds_pkg::MRK_RST7)) begin
          phase_next = ihds_pkg::PH_SEEK;
        end else begin
          marker_next = byte_value;
          phase_next  = ihds_pkg::PH_LENHI;
        end
      end
      ihds_pkg::PH_LENHI: begin
        len_hi_next = byte_value;
        phase_next  = ihds_pkg::PH_LENLO;
      end
      ihds_pkg::PH_LENLO: begin
        priority if (ihds_pkg::is_sof(marker)) begin
          count_next = ihds_pkg::SOF_START;
          phase_next = ihds_pkg::PH_SOF;
        end else if (seg_len <= 16'd2) begin
          phase_next = ihds_pkg::PH_SEEK;
        end else begin
          count_next = seg_len - 16'd2;
          phase_next = ihds_pkg::PH_SKIP;
        end
      end
      ihds_pkg::PH_SKIP: begin
        count_next = count_dec;
        if (count_dec == 16'd0) begin
          phase_next = ihds_pkg::PH_SEEK;
        end
      end
      ihds_pkg::PH_SOF: begin
        evt.hgt_hi    = (count == ihds_pkg::SOF_HGT_HI);
        evt.hgt_lo    = (count == ihds_pkg::SOF_HGT_LO);
        evt.wid_hi    = (count == ihds_pkg::SOF_WID_HI);
        evt.wid_lo    = (count == ihds_pkg::SOF_WID_LO);
        evt.dec_found = (count == ihds_pkg::SOF_COMP);
        count_next    = count + 16'd1;
      end
      default: begin
        phase_next = ihds_pkg::PH_SEEK;
      end
    endcase
  end

  // Hold walk state; clear at end of file
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      phase <= ihds_pkg::PH_SEEK;
    end else if (en) begin
      phase <= phase_next;
    end
  end

  // Segment payload registers are always written before they are read
  always_ff @(posedge clk) begin
    if (en) begin
      marker <= marker_next;
      len_hi <= len_hi_next;
      count  <= count_next;
    end
  end

endmodule

[src/image_header_dimension_sniffer.sv]
// ----------------------------------------------------------------------------
// image_header_dimension_sniffer
// Recognizes PNG, BMP or JPEG from a byte stream and reports the image
// dimensions with one result request on the last byte of each file.
// ----------------------------------------------------------------------------
//
//   channel | handshake           | payload
//   --------+---------------------+------------------------------------------
//   input   | in_valid, in_ready  | byte_value[7:0], last_byte
//   result  | out_valid, out_ready| found, format[1:0], width[31:0],
//           |                     | height[31:0], channels[7:0]
//
// One byte is taken per cycle while in_ready is high; a byte carrying last_byte
// gives its result in the following cycle from the result register.
// Parse state sits in registers updated once per accepted byte; a single
// level of compare/shift logic sits between those and the result register.
// in_ready drops only while a result is held and out_ready is low.
// Synchronous reset returns the parser to the start of a file; the parser
// also returns there after every last byte.
// ----------------------------------------------------------------------------
module image_header_dimension_sniffer #(
  parameter int unsigned POSITION_BITS = ihds_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  byte_value,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        found,
  output logic [1:0]  format,
  output logic [31:0] width,
  output logic [31:0] height,
  output logic [7:0]  channels
);

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  logic                     acc;
  logic [POSITION_BITS-1:0] pos, pos_next;
  ihds_pkg::fmt_t           fmt, fmt_next;
  ihds_pkg::dec_t           decided, decided_next;
  logic [31:0]              width_shift, width_shift_next;
  logic [31:0]              height_shift, height_shift_next;
  logic [7:0]               channel_hold, channel_hold_next;
  logic                     jpeg_en;
  ihds_pkg::jpeg_evt_t      jpeg_evt;
  logic                     out_valid_next;

  assign in_ready = !out_valid || out_ready;
  assign acc      = in_valid && in_ready;

  // Feed the JPEG walker from the third byte on while undecided
  assign jpeg_en = acc && (decided == ihds_pkg::DEC_OPEN) &&
                   (fmt == ihds_pkg::FMT_JPEG) &&
                   (pos != POSITION_BITS'(0)) && (pos != POSITION_BITS'(1));

  ihds_jpeg u_jpeg (
    .clk        (clk),
    .rst        (rst),
    .en         (jpeg_en),
    .clr        (acc && last_byte),
    .byte_value (byte_value),
    .evt        (jpeg_evt)
  );

  // Advance the saturating position
  assign pos_next = (pos == POS_MAX) ? pos : pos + POSITION_BITS'(1);

  // Classify and capture one byte
  always_comb begin
    fmt_next          = fmt;
    decided_next      = decided;
    width_shift_next  = width_shift;
    height_shift_next = height_shift;
    channel_hold_next = channel_hold;
    if (decided == ihds_pkg::DEC_OPEN) begin
      if (pos == POSITION_BITS'(0)) begin
        priority if (byte_value == ihds_pkg::LEAD_PNG) begin
          fmt_next = ihds_pkg::FMT_PNG;
        end else if (byte_value == ihds_pkg::LEAD_BMP) begin
          fmt_next = ihds_pkg::FMT_BMP;
        end else if (byte_value == ihds_pkg::MRK_PREFIX) begin
          fmt_next = ihds_pkg::FMT_JPEG;
        end else begin
          fmt_next     = ihds_pkg::FMT_NONE;
          decided_next = ihds_pkg::DEC_NONE;
        end
      end else begin
        unique case (fmt)
          ihds_pkg::FMT_PNG: begin
            priority if (pos < POSITION_BITS'(8)) begin
              if (byte_value != ihds_pkg::png_magic(pos[2:0])) begin
                decided_next = ihds_pkg::DEC_NONE;
              end
            end else if (pos >= POSITION_BITS'(12) && pos < POSITION_BITS'(16)) begin
              if (byte_value != ihds_pkg::png_ihdr(pos[1:0])) begin
                decided_next = ihds_pkg::DEC_NONE;
              end
            end else if (pos >= POSITION_BITS'(16) && pos < POSITION_BITS'(20)) begin
              width_shift_next = {width_shift[23:0], byte_value};
            end else if (pos >= POSITION_BITS'(20) && pos < POSITION_BITS'(24)) begin
              height_shift_next = {height_shift[23:0], byte_value};
              if (pos == POSITION_BITS'(23)) begin
                channel_hold_next = ihds_pkg::CHAN_DEF;
                decided_next      = ihds_pkg::DEC_FOUND;
              end
            end else begin
              decided_next = decided;
            end
          end
          ihds_pkg::FMT_BMP: begin
            priority if (pos == POSITION_BITS'(1)) begin
              if (byte_value != ihds_pkg::BMP_SECOND) begin
                decided_next = ihds_pkg::DEC_NONE;
              end
            end else if (pos >= POSITION_BITS'(18) && pos < POSITION_BITS'(22)) begin
              width_shift_next = {byte_value, width_shift[31:8]};
            end else if (pos >= POSITION_BITS'(22) && pos < POSITION_BITS'(26)) begin
              height_shift_next = {byte_value, height_shift[31:8]};
              if (pos == POSITION_BITS'(25)) begin
                width_shift_next  = ihds_pkg::mag32(width_shift);
                height_shift_next = ihds_pkg::mag32({byte_value, height_shift[31:8]});
                channel_hold_next = ihds_pkg::CHAN_DEF;
                decided_next      = ihds_pkg::DEC_FOUND;
              end
            end else begin
              decided_next = decided;
            end
          end
          ihds_pkg::FMT_JPEG: begin
            if (pos == POSITION_BITS'(1)) begin
              if (byte_value != ihds_pkg::MRK_SOI) begin
                decided_next = ihds_pkg::DEC_NONE;
              end
            end else begin
              if (jpeg_evt.dec_none) begin
                decided_next = ihds_pkg::DEC_NONE;
              end
              if (jpeg_evt.dec_found) begin
                channel_hold_next = (byte_value == 8'd0) ? ihds_pkg::CHAN_DEF : byte_value;
                decided_next      = ihds_pkg::DEC_FOUND;
              end
              if (jpeg_evt.hgt_hi) begin
                height_shift_next = {16'd0, byte_value, 8'd0};
              end
              if (jpeg_evt.hgt_lo) begin
                height_shift_next = height_shift | {24'd0, byte_value};
              end
              if (jpeg_evt.wid_hi) begin
                width_shift_next = {16'd0, byte_value, 8'd0};
              end
              if (jpeg_evt.wid_lo) begin
                width_shift_next = width_shift | {24'd0, byte_value};
              end
            end
          end
          default: begin
            decided_next = ihds_pkg::DEC_NONE;
          end
        endcase
      end
    end
  end

  assign out_valid_next = (acc && last_byte) || (out_valid && !out_ready);

  // Hold parse control state; restart after the last byte
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      fmt       <= ihds_pkg::FMT_NONE;
      decided   <= ihds_pkg::DEC_OPEN;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (acc) begin
        if (last_byte) begin
          pos     <= '0;
          fmt     <= ihds_pkg::FMT_NONE;
          decided <= ihds_pkg::DEC_OPEN;
        end else begin
          pos     <= pos_next;
          fmt     <= fmt_next;
          decided <= decided_next;
        end
      end
    end
  end

  // Capture dimension payload
  always_ff @(posedge clk) begin
    if (acc) begin
      width_shift  <= width_shift_next;
      height_shift <= height_shift_next;
      channel_hold <= channel_hold_next;
    end
  end

  // Load the result register on the last byte
  always_ff @(posedge clk) begin
    if (acc && last_byte) begin
      if (decided_next == ihds_pkg::DEC_FOUND) begin
        found    <= 1'b1;
        format   <= fmt_next;
        width    <= width_shift_next;
        height   <= height_shift_next;
        channels <= channel_hold_next;
      end else begin
        found    <= 1'b0;
        format   <= ihds_pkg::FMT_NONE;
        width    <= '0;
        height   <= '0;
        channels <= '0;
      end
    end
  end

`ifndef SYNTH
  // A last byte always yields a pending result
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=> out_valid)
    else $error("last byte accepted without a result");

  // A not-found result carries all-zero fields
  a_none_is_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |->
      (format == ihds_pkg::FMT_NONE && width == 32'd0 &&
       height == 32'd0 && channels == 8'd0))
    else $error("not-found result has nonzero fields");

  // A found result names a format and a nonzero channel count
  a_found_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (format != ihds_pkg::FMT_NONE && channels != 8'd0))
    else $error("found result with no format or zero channels");

  // The parser restarts at position zero after a last byte
  a_restart: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && last_byte) |=>
      (pos == '0 && decided == ihds_pkg::DEC_OPEN))
    else $error("parser did not restart after last byte");
`endif

endmodule
